// File: rtl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

   // Result kinds carried on the result channel.
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_URL_MODE  = 1'd1;

   // One item can cause at most four results.
   localparam int unsigned MAX_RESULTS = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   // Everything one input item produces, handed from the decoder to the result buffer.
   typedef struct packed {
      logic [2:0]                   num;
      result_type [MAX_RESULTS-1:0] items;
   } step_out_type;

endpackage

`default_nettype wire

// File: rtl/b64d_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one text byte per item.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Result channel: decoded bytes and the closing status.
interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] decoded_byte;
   logic       final_result;

   modport source (output valid, output result_kind, output decoded_byte,
                   output final_result, input ready);
   modport sink   (input valid, input result_kind, input decoded_byte,
                   input final_result, output ready);
endinterface

// Configuration write channel.
interface b64d_csr_if;
   logic       valid;
   logic       ready;
   logic [0:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/b64d_core.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_core
   import b64d_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   step_en,
   input  wire logic [7:0] text_byte,
   input  wire logic   end_of_text,
   b64d_csr_if.sink    csr_bus,
   output step_out_type step_out
);

   typedef enum logic [1:0] {
      PH_DECODING = 2'd0,
      PH_SEEKPAD  = 2'd1,
      PH_DONE     = 2'd2,
      PH_ERROR    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CC_SYMBOL,
      CC_STD_HIGH,
      CC_URL_HIGH,
      CC_PAD,
      CC_SKIP,
      CC_BAD
   } char_class_type;

   // Character class of one byte, independent of the alphabet in use.
   function automatic char_class_type classify(input logic [7:0] b);
      char_class_type c;
      c = CC_BAD;
      if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
          (b >= 8'h30 && b <= 8'h39)) begin
         c = CC_SYMBOL;
      end else if (b == 8'h2B || b == 8'h2F) begin
         c = CC_STD_HIGH;
      end else if (b == 8'h2D || b == 8'h5F) begin
         c = CC_URL_HIGH;
      end else if (b == 8'h3D) begin
         c = CC_PAD;
      end else if (b == 8'hA0 || b == 8'h08 || b == 8'h09 || b == 8'h0A ||
                   b == 8'h0C || b == 8'h0D || b == 8'h20 || b == 8'h27) begin
         c = CC_SKIP;
      end
      return c;
   endfunction

   // Six-bit symbol value; both spellings of 62 and 63 map alike.
   function automatic logic [5:0] symbol_value(input logic [7:0] b);
      logic [5:0] v;
      v = 6'd0;
      if (b >= 8'h41 && b <= 8'h5A) begin
         v = 6'(b - 8'h41);
      end else if (b >= 8'h61 && b <= 8'h7A) begin
         v = 6'(b - 8'h61 + 8'd26);
      end else if (b >= 8'h30 && b <= 8'h39) begin
         v = 6'(b - 8'h30 + 8'd52);
      end else if (b == 8'h2B || b == 8'h2D) begin
         v = 6'd62;
      end else if (b == 8'h2F || b == 8'h5F) begin
         v = 6'd63;
      end
      return v;
   endfunction

   logic [7:0]  delim_ff;
   logic        url_cfg_ff;
   logic [23:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        url_ff, url_in;
   logic        saw_ff, saw_in;
   phase_type   phase_ff, phase_in;

   char_class_type cls;
   logic [5:0]     sym;
   logic           add_sym;
   logic           ok;
   logic [2:0]     n;
   step_out_type   out_c;

   assign csr_bus.ready = 1'b1;

   // Decode step: classify the byte, update the group and collect results.
   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      url_in   = url_ff;
      saw_in   = saw_ff;
      phase_in = phase_ff;
      cls      = classify(text_byte);
      sym      = symbol_value(text_byte);
      add_sym  = 1'b0;
      ok       = 1'b0;
      n        = 3'd0;
      out_c    = '0;

      unique case (phase_ff)
         PH_DECODING: begin
            if (delim_ff != 8'd0 && text_byte == delim_ff) begin
               phase_in = PH_DONE;
            end else begin
               case (cls)
                  CC_SYMBOL: add_sym = 1'b1;
                  CC_STD_HIGH: begin
                     if (url_ff) begin
                        phase_in = PH_ERROR;
                     end else begin
                        saw_in  = 1'b1;
                        add_sym = 1'b1;
                     end
                  end
                  CC_URL_HIGH: begin
                     // A dash or underscore in standard mode switches alphabets unless a plus or slash came first.
                     if (url_ff || !saw_ff) begin
                        url_in  = 1'b1;
                        add_sym = 1'b1;
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
                  CC_PAD: begin
                     if (cnt_ff == 2'd3) begin
                        out_c.items[n[1:0]] = '{KIND_DATA, acc_ff[17:10], 1'b0};
                        n = n + 3'd1;
                        out_c.items[n[1:0]] = '{KIND_DATA, acc_ff[9:2], 1'b0};
                        n = n + 3'd1;
                        acc_in   = '0;
                        cnt_in   = 2'd0;
                        phase_in = PH_DONE;
                     end else if (cnt_ff == 2'd2) begin
                        phase_in = PH_SEEKPAD;
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
                  CC_SKIP: ;
                  default: phase_in = PH_ERROR;
               endcase
            end
         end
         PH_SEEKPAD: begin
            if (text_byte == 8'h3D) begin
               out_c.items[n[1:0]] = '{KIND_DATA, acc_ff[11:4], 1'b0};
               n = n + 3'd1;
               acc_in   = '0;
               cnt_in   = 2'd0;
               phase_in = PH_DONE;
            end
         end
         PH_DONE, PH_ERROR: ;
         default: ;
      endcase

      // Shift in a symbol; the fourth one completes three bytes.
      if (add_sym) begin
         acc_in = {acc_ff[17:0], sym};
         if (cnt_ff == 2'd3) begin
            out_c.items[n[1:0]] = '{KIND_DATA, acc_in[23:16], 1'b0};
            n = n + 3'd1;
            out_c.items[n[1:0]] = '{KIND_DATA, acc_in[15:8], 1'b0};
            n = n + 3'd1;
            out_c.items[n[1:0]] = '{KIND_DATA, acc_in[7:0], 1'b0};
            n = n + 3'd1;
            acc_in = '0;
            cnt_in = 2'd0;
         end else begin
            cnt_in = cnt_ff + 2'd1;
         end
      end

      // Close the string: flush an unpadded URL group and report status.
      if (end_of_text) begin
         if (phase_in == PH_ERROR || phase_in == PH_SEEKPAD) begin
            ok = 1'b0;
         end else if (cnt_in == 2'd0) begin
            ok = 1'b1;
         end else if (url_in && cnt_in == 2'd3) begin
            out_c.items[n[1:0]] = '{KIND_DATA, acc_in[17:10], 1'b0};
            n = n + 3'd1;
            out_c.items[n[1:0]] = '{KIND_DATA, acc_in[9:2], 1'b0};
            n = n + 3'd1;
            ok = 1'b1;
         end else if (url_in && cnt_in == 2'd2) begin
            out_c.items[n[1:0]] = '{KIND_DATA, acc_in[11:4], 1'b0};
            n = n + 3'd1;
            ok = 1'b1;
         end
         out_c.items[n[1:0]] = '{(ok ? KIND_OK : KIND_ERR), 8'd0, 1'b1};
         n = n + 3'd1;
         acc_in   = '0;
         cnt_in   = 2'd0;
         url_in   = url_cfg_ff;
         saw_in   = 1'b0;
         phase_in = PH_DECODING;
      end
      out_c.num = n;
   end

   assign step_out = out_c;

   // Configuration registers and decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff   <= 8'd0;
         url_cfg_ff <= 1'b0;
         acc_ff     <= '0;
         cnt_ff     <= 2'd0;
         url_ff     <= 1'b0;
         saw_ff     <= 1'b0;
         phase_ff   <= PH_DECODING;
      end else begin
         if (csr_bus.valid) begin
            if (csr_bus.index == CSR_DELIMITER) begin
               delim_ff <= csr_bus.data;
            end else if (csr_bus.index == CSR_URL_MODE) begin
               url_cfg_ff <= csr_bus.data[0];
            end
         end
         if (step_en) begin
            acc_ff   <= acc_in;
            cnt_ff   <= cnt_in;
            url_ff   <= url_in;
            saw_ff   <= saw_in;
            phase_ff <= phase_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/b64d_result_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_result_buf
   import b64d_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire step_out_type  step_out,
   output logic               can_load,
   b64d_rsp_if.source         rsp_bus
);

   result_type [MAX_RESULTS-1:0] items_ff;
   logic [2:0] count_ff;
   logic [1:0] rd_ff;
   logic       pop;
   result_type head;

   assign head           = items_ff[rd_ff];
   assign rsp_bus.valid        = (count_ff != 3'd0);
   assign rsp_bus.result_kind  = head.kind;
   assign rsp_bus.decoded_byte = head.data;
   assign rsp_bus.final_result = head.last;
   assign pop            = rsp_bus.valid && rsp_bus.ready;

   // A new item may land once the last held result leaves in this cycle.
   assign can_load = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_bus.ready);

   // Result items of one input item, drained one per cycle while the receiver is ready.
   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= step_out.items;
      end
      if (reset) begin
         count_ff <= 3'd0;
         rd_ff    <= 2'd0;
      end else if (load) begin
         count_ff <= step_out.num;
         rd_ff    <= 2'd0;
      end else if (pop) begin
         count_ff <= count_ff - 3'd1;
         rd_ff    <= rd_ff + 2'd1;
      end
   end

endmodule

`default_nettype wire

// File: rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 decoder. Each input item is one text byte; decoded bytes
// leave one per result item as soon as their group completes, and the item
// that carries end_of_text also yields one status result (success or error).
// An item causing zero or one result is taken every cycle while results are
// taken; one causing more (at most four) holds the input until its last result
// leaves; its results drain via the single result port of a four-entry result
// register. Registers: index 0 is the delimiter byte (0 disables it), index 1
// selects the URL-safe alphabet from the next string on. Write them while idle.
module base64_stream_decoder
   import b64d_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   b64d_req_if.sink   req_bus,
   b64d_rsp_if.source rsp_bus,
   b64d_csr_if.sink   csr_bus
);

   step_out_type step_out;
   logic         can_load;
   logic         step_en;

   assign req_bus.ready = can_load;
   assign step_en       = req_bus.valid && can_load;

   b64d_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .text_byte   (req_bus.text_byte),
      .end_of_text (req_bus.end_of_text),
      .csr_bus     (csr_bus),
      .step_out    (step_out)
   );

   b64d_result_buf u_result_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (step_en),
      .step_out (step_out),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// File: rtl/b64d_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_checker
   import b64d_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_end_of_text,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_result_kind,
   input wire logic [7:0] rsp_decoded_byte,
   input wire logic       rsp_final_result
);

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_decoded_byte) && $stable(rsp_final_result))
      else $error("stalled result item changed");

   // Data items are never final; status items are final and carry a zero byte.
   a_kind_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == KIND_DATA && !rsp_final_result) ||
      ((rsp_result_kind == KIND_OK || rsp_result_kind == KIND_ERR) &&
       rsp_final_result && rsp_decoded_byte == 8'd0))
      else $error("result kind and final flag disagree");

   // The closing input item always leaves a status result waiting.
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_text |=> rsp_valid)
      else $error("no result after end of text");

   // New input is only taken when the pending result leaves in the same cycle.
   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_ready)
      else $error("input taken while results still pending");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_end_of_text  (req_bus.end_of_text),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_kind  (rsp_bus.result_kind),
   .rsp_decoded_byte (rsp_bus.decoded_byte),
   .rsp_final_result (rsp_bus.final_result)
);

`default_nettype wire

// File: dv/base64_stream_decoder_test.sv
`timescale 1ns / 1ps

module base64_stream_decoder_test;
   import b64d_pkg::*;

   // Character codes that steer decoding.
   localparam logic [7:0] CH_PAD   = 8'h3D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   // Classes returned by the symbol lookup beside the 64 symbol values.
   localparam int SYM_SKIP = 64;
   localparam int SYM_PAD  = 65;
   localparam int SYM_BAD  = 66;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int NUM_PHASES    = 7;
   localparam int PHASE_ITEMS   = 40;

   typedef enum logic [1:0] {
      PH_DECODE, PH_SEEK_PAD, PH_CLOSED, PH_FAILED
   } decode_phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_item_type;

   logic clock;
   logic reset = 1'b1;

   b64d_req_if req_bus ();
   b64d_rsp_if rsp_bus ();
   b64d_csr_if csr_bus ();

   base64_stream_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Text waiting to be sent, and the decoder output still owed for accepted text.
   text_item_type text_to_send[$];
   result_type    decoded_due[$];
   logic [7:0]    chars[$];
   int            sent_total = 0;
   int            mismatches = 0;

   // Run control shared between the stimulus and the channel processes.
   bit   calm        = 1'b0;
   bit   hold_req    = 1'b0;
   logic rsp_hold_on = 1'b0;

   // Register settings visited by the random phases.
   logic [7:0] delim_plan [0:NUM_PHASES-1] =
      '{8'h2E, 8'hFF, 8'h00, 8'h3D, 8'h41, 8'h01, 8'h0A};
   bit         url_plan   [0:NUM_PHASES-1] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   // Decoder state as predicted, plus our copy of the registers.
   logic [7:0]       delim_cfg;
   logic             url_cfg;
   logic [23:0]      acc_bits;
   logic [1:0]       sym_count;
   logic             url_live;
   logic             saw_std_symbol;
   decode_phase_type phase;

   // Maps a text byte to its 6-bit symbol, or to a skip, pad or error class.
   function automatic int sextet_of(input logic [7:0] ch, input logic url);
      int c;
      c = ch;
      if (c >= 65 && c <= 90) return c - 65;
      if (c >= 97 && c <= 122) return c - 71;
      if (c >= 48 && c <= 57) return c + 4;
      if (ch == CH_PAD) return SYM_PAD;
      case (ch)
         8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20, 8'h27, 8'hA0: return SYM_SKIP;
         default: ;
      endcase
      if (url) begin
         if (ch == CH_DASH) return 62;
         if (ch == CH_UNDER) return 63;
      end else begin
         if (ch == CH_PLUS) return 62;
         if (ch == CH_SLASH) return 63;
      end
      return SYM_BAD;
   endfunction

   function automatic logic [7:0] char_of(input int v, input logic url);
      if (v < 26) return 8'(65 + v);
      if (v < 52) return 8'(71 + v);
      if (v < 62) return 8'(v - 4);
      if (v == 62) return url ? CH_DASH : CH_PLUS;
      return url ? CH_UNDER : CH_SLASH;
   endfunction

   task automatic restart_string();
      acc_bits       = '0;
      sym_count      = '0;
      url_live       = url_cfg;
      saw_std_symbol = 1'b0;
      phase          = PH_DECODE;
   endtask

   task automatic owe(input logic [1:0] kind, input logic [7:0] data, input logic last);
      result_type r;
      r.kind = kind;
      r.data = data;
      r.last = last;
      decoded_due.push_back(r);
   endtask

   // Shift one symbol in; the fourth symbol of a group releases three bytes.
   task automatic take_symbol(input int v);
      acc_bits = {acc_bits[17:0], 6'(v)};
      if (sym_count == 2'd3) begin
         owe(KIND_DATA, acc_bits[23:16], 1'b0);
         owe(KIND_DATA, acc_bits[15:8], 1'b0);
         owe(KIND_DATA, acc_bits[7:0], 1'b0);
         acc_bits  = '0;
         sym_count = '0;
      end else begin
         sym_count = sym_count + 2'd1;
      end
   endtask

   // Predicts the output caused by one accepted text byte.
   task automatic decode_char(input logic [7:0] ch, input logic eot);
      int   s;
      logic good;
      if (phase == PH_DECODE) begin
         if (delim_cfg != 8'h00 && ch == delim_cfg) begin
            phase = PH_CLOSED;
         end else begin
            s = sextet_of(ch, url_live);
            if (s < 64) begin
               if (!url_live && (ch == CH_PLUS || ch == CH_SLASH)) saw_std_symbol = 1'b1;
               take_symbol(s);
            end else if (s == SYM_PAD) begin
               if (sym_count == 2'd3) begin
                  owe(KIND_DATA, acc_bits[17:10], 1'b0);
                  owe(KIND_DATA, acc_bits[9:2], 1'b0);
                  acc_bits  = '0;
                  sym_count = '0;
                  phase     = PH_CLOSED;
               end else if (sym_count == 2'd2) begin
                  phase = PH_SEEK_PAD;
               end else begin
                  phase = PH_FAILED;
               end
            end else if (s == SYM_BAD) begin
               // A URL symbol in standard mode switches alphabets unless '+' or '/' came first.
               if (!url_live && (ch == CH_DASH || ch == CH_UNDER) && !saw_std_symbol) begin
                  url_live = 1'b1;
                  take_symbol(ch == CH_DASH ? 62 : 63);
               end else begin
                  phase = PH_FAILED;
               end
            end
         end
      end else if (phase == PH_SEEK_PAD && ch == CH_PAD) begin
         owe(KIND_DATA, acc_bits[11:4], 1'b0);
         acc_bits  = '0;
         sym_count = '0;
         phase     = PH_CLOSED;
      end

      // The closing byte judges what is left and reports the status.
      if (eot) begin
         if (phase == PH_FAILED || phase == PH_SEEK_PAD) begin
            good = 1'b0;
         end else if (sym_count == 2'd0) begin
            good = 1'b1;
         end else if (url_live && sym_count == 2'd3) begin
            owe(KIND_DATA, acc_bits[17:10], 1'b0);
            owe(KIND_DATA, acc_bits[9:2], 1'b0);
            good = 1'b1;
         end else if (url_live && sym_count == 2'd2) begin
            owe(KIND_DATA, acc_bits[11:4], 1'b0);
            good = 1'b1;
         end else begin
            good = 1'b0;
         end
         owe(good ? KIND_OK : KIND_ERR, 8'h00, 1'b1);
         restart_string();
      end
   endtask

   task automatic push_char(input logic [7:0] ch, input logic eot);
      text_item_type it;
      it.text_byte   = ch;
      it.end_of_text = eot;
      text_to_send.push_back(it);
      sent_total++;
   endtask

   task automatic push_text(input string s, input bit close);
      int i;
      for (i = 0; i < s.len(); i++) push_char(s[i], close && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 7))
         0: return 8'h08;
         1: return 8'h09;
         2: return 8'h0A;
         3: return 8'h0C;
         4: return 8'h0D;
         5: return 8'h20;
         6: return 8'h27;
         default: return 8'hA0;
      endcase
   endfunction

   // Encodes random bytes into chars; with mix set, symbols 62 and 63 use either alphabet.
   task automatic build_encoded(input int nbytes, input logic url, input logic pad,
                                input logic mix);
      logic [7:0]  raw[$];
      logic [23:0] grp;
      int          i, k, left, nsym;
      chars.delete();
      for (i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 3) == 0) raw.push_back(8'hF8 | 8'($urandom_range(0, 7)));
         else raw.push_back(8'($urandom_range(0, 255)));
      end
      for (i = 0; i < nbytes; i += 3) begin
         left = nbytes - i;
         grp  = {raw[i], 16'h0000};
         if (left > 1) grp[15:8] = raw[i+1];
         if (left > 2) grp[7:0] = raw[i+2];
         nsym = (left >= 3) ? 4 : left + 1;
         for (k = 0; k < 4; k++) begin
            if (k < nsym)
               chars.push_back(char_of(int'(grp[23-6*k -: 6]),
                                       mix ? 1'($urandom_range(0, 1)) : url));
            else if (pad)
               chars.push_back(CH_PAD);
         end
      end
   endtask

   // Queues chars as one string, sprinkling blanks if asked, with end_of_text on the last byte.
   task automatic push_chars(input bit blanks);
      int i;
      if (chars.size() == 0) begin
         push_char(pick_blank(), 1'b1);
         return;
      end
      for (i = 0; i < chars.size(); i++) begin
         if (blanks && $urandom_range(0, 9) == 0) push_char(pick_blank(), 1'b0);
         push_char(chars[i], i == chars.size() - 1);
      end
   endtask

   // One random string: mostly well formed, the rest mixed, cut, padded oddly or noise.
   task automatic random_string(input logic url);
      int sel, n, pos, i;
      sel = $urandom_range(0, 19);
      n   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
      if (sel < 11) begin
         build_encoded(n, url, url ? 1'($urandom_range(0, 1)) : 1'b1, 1'b0);
      end else if (sel < 13) begin
         build_encoded(n, url, 1'($urandom_range(0, 1)), 1'b1);
      end else if (sel < 15) begin
         // Junk between the two pads is ignored.
         build_encoded(3 * $urandom_range(0, 2) + 1, url, 1'b1, 1'b0);
         pos = chars.size() - 1;
         for (i = $urandom_range(1, 3); i > 0; i--)
            chars.insert(pos, 8'($urandom_range(0, 255)));
      end else if (sel < 17) begin
         build_encoded(n, url, 1'($urandom_range(0, 1)), 1'b0);
         chars.insert($urandom_range(0, chars.size()), delim_cfg);
      end else if (sel < 19) begin
         build_encoded(n, url, 1'($urandom_range(0, 1)), 1'b0);
         if (chars.size() == 0) begin
            chars.push_back(CH_PAD);
         end else begin
            pos = $urandom_range(0, chars.size() - 1);
            case ($urandom_range(0, 2))
               0: chars[pos] = 8'($urandom_range(0, 255));
               1: chars.insert(pos, CH_PAD);
               default: chars.delete(pos);
            endcase
         end
      end else begin
         chars.delete();
         for (i = $urandom_range(1, 8); i > 0; i--)
            chars.push_back(8'($urandom_range(0, 255)));
      end
      push_chars($urandom_range(0, 3) == 0);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_DELIMITER) delim_cfg = value;
      else url_cfg = value[0];
   endtask

   // Waits until all text is in and every owed result is out, then lets the block go quiet.
   task automatic settle();
      while (text_to_send.size() != 0 || req_bus.valid || decoded_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Main stimulus.
   initial begin
      int p, phase_start;
      req_bus.valid       = 1'b0;
      req_bus.text_byte   = 8'h00;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_DELIMITER;
      csr_bus.data        = 8'h00;
      delim_cfg           = 8'h00;
      url_cfg             = 1'b0;
      restart_string();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      csr_write(CSR_DELIMITER, 8'h00);
      csr_write(CSR_URL_MODE, 8'h00);

      // Directed strings: a full group with a 0xA0 skip, one-byte padding with an
      // ignored byte between the pads, two-byte padding, a URL symbol after '+',
      // a pad after one symbol, a zero byte with no delimiter, and a clean switch
      // to the URL alphabet.
      push_text("TW", 1'b0);
      push_char(8'hA0, 1'b0);
      push_text("Fu", 1'b1);
      push_text("QQ=", 1'b0);
      push_char(8'hFF, 1'b0);
      push_text("=", 1'b1);
      push_text("QUI=", 1'b1);
      push_text("+/-_", 1'b1);
      push_text("Q=", 1'b1);
      push_char(8'h00, 1'b1);
      push_text("-_-_", 1'b1);
      settle();

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p == 2) hold_req = 1'b1;
         if (p == NUM_PHASES - 1) calm = 1'b1;
         csr_write(CSR_DELIMITER, delim_plan[p]);
         csr_write(CSR_URL_MODE, {7'd0, url_plan[p]});
         phase_start = sent_total;
         while (sent_total - phase_start < PHASE_ITEMS) random_string(url_plan[p]);
         // Leave one string open so the next register change lands mid-string.
         if (p == 0) push_text("TW", 1'b0);
         settle();
      end

      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && decoded_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // One long receiver hold-off while the sender keeps offering text.
   initial begin
      wait (hold_req);
      @(posedge clock);
      rsp_hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold_on <= 1'b0;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

   // Text driver: predicts on every accepted item, then offers the next one or idles.
   int            send_gap = 0;
   text_item_type next_item;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            decode_char(req_bus.text_byte, req_bus.end_of_text);
         if (req_bus.valid && !req_bus.ready) begin
            // The offered item stays until it is taken.
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 9);
            req_bus.valid <= 1'b0;
         end else if (text_to_send.size() != 0) begin
            next_item = text_to_send.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.text_byte   <= next_item.text_byte;
            req_bus.end_of_text <= next_item.end_of_text;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result monitor: checks each accepted result against the oldest owed one.
   int         rsp_stall = 0;
   result_type owed;
   result_type seen;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t: %s: expected kind %0d byte %02h final %0d, ",
                   "got kind %0d byte %02h final %0d"},
                  $realtime, what, owed.kind, owed.data, owed.last,
                  seen.kind, seen.data, seen.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.kind = rsp_bus.result_kind;
            seen.data = rsp_bus.decoded_byte;
            seen.last = rsp_bus.final_result;
            if (decoded_due.size() == 0) begin
               owed = '0;
               report_mismatch("result with nothing owed");
            end else begin
               owed = decoded_due.pop_front();
               if (seen.kind !== owed.kind || seen.data !== owed.data ||
                   seen.last !== owed.last)
                  report_mismatch("result differs");
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall = $urandom_range(0, 9);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !rsp_hold_on;
         end
      end
   end

endmodule
